FILE: src/sstp_pkg.sv
`default_nettype none
package sstp_pkg;

  localparam int TICK_W       = 12;
  localparam int NOTE_W       = 7;
  localparam int DUR_W        = 8;
  localparam int CH_W         = 5;
  localparam int CNT_W        = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 12;
  localparam int EV_SLOTS_DEF = 32;
  localparam int PL_SLOTS_DEF = 16;

  // input function codes
  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_ADD    = 3'd1;
  localparam logic [2:0] FN_REMOVE = 3'd2;
  localparam logic [2:0] FN_CUE    = 3'd3;
  localparam logic [2:0] FN_FLUSH  = 3'd4;
  localparam logic [2:0] FN_COUNT  = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_ON   = 2'd0;
  localparam logic [1:0] KIND_OFF  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // mute status codes
  localparam logic [1:0] MS_OFF      = 2'd0;
  localparam logic [1:0] MS_ON       = 2'd1;
  localparam logic [1:0] MS_ON_CUED  = 2'd2;
  localparam logic [1:0] MS_OFF_CUED = 2'd3;

  // speed codes
  localparam logic [2:0] SPD_X1      = 3'd0;
  localparam logic [2:0] SPD_X2      = 3'd1;
  localparam logic [2:0] SPD_QUARTER = 3'd2;
  localparam logic [2:0] SPD_THIRD   = 3'd3;
  localparam logic [2:0] SPD_HALF    = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAST_TICK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_CH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE = 3'd4;

  typedef struct packed {
    logic [2:0]        func;
    logic [TICK_W-1:0] tick_value;
    logic [TICK_W-1:0] tick_end;
    logic [NOTE_W-1:0] note_number;
    logic [NOTE_W-1:0] note_velocity;
    logic [DUR_W-1:0]  note_duration;
    logic              mute_wanted;
  } in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CH_W-1:0]   channel;
    logic [NOTE_W-1:0] note_out;
    logic [NOTE_W-1:0] velocity_out;
    logic [CNT_W-1:0]  match_count;
    logic [TICK_W-1:0] track_time;
    logic [1:0]        mute_status;
    logic              last;
  } out_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] vel;
    logic [DUR_W-1:0]  dur;
  } ev_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] vel;
    logic [DUR_W-1:0]  dur;
  } held_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TIME, ST_ON, ST_OFF, ST_ADD, ST_REM, ST_CNT, ST_FLUSH, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_TIME, OP_ON, OP_OFF, OP_FLUSH, OP_ADD, OP_REM, OP_REM_FIN,
    OP_CNT, OP_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic on_due;
    logic note_ok;
    logic off_emit;
    logic slot_valid;
    logic slot_end;
    logic add_fin;
    logic scan_end;
    logic table_full;
  } status_t;

endpackage
`default_nettype wire

FILE: src/sstp_if.sv
`default_nettype none
interface sstp_in_if import sstp_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sstp_out_if import sstp_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/step_sequencer_track_player.sv
// step sequencer track player: plays one track of a pattern
// channels: in_ch carries one command word (tick, add, remove, cue mute,
// flush, count); out_ch returns note-on / note-off words and then one done
// word with last set; every word carries track time and mute status
// configuration: cfg_we / cfg_index / cfg_data write pattern length, speed,
// channel, note-as-channel and transpose; the user must write them only while
// the block is idle, as the block itself does not enforce this
// one word in service at a time; in_ch.ready is high only while the sequencer
// is idle; tick steps the time, emits due events as note-on words, then scans
// every played slot; add moves entries up until its place is found; remove
// and count scan the filled entries; flush scans every played slot; cue mute,
// unknown codes and add to a full table go straight to the done word; the
// event table and played buffer are scanned one entry per cycle through a
// single read port each; a stalled receiver holds the output register; the
// scan waits on each step with a word to send, so nothing is lost or repeated
// reset empties the event table and played buffer, zeroes time, pointer,
// prescaler and mute state, and loads the register defaults
`default_nettype none
module step_sequencer_track_player import sstp_pkg::*; #(
  parameter int EVENT_SLOTS  = EV_SLOTS_DEF,
  parameter int PLAYED_SLOTS = PL_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  sstp_in_if.sink                    in_ch,
  sstp_out_if.source                 out_ch
);

  // controller to datapath commands and status
  cmd_t    cmd;
  status_t status;

  sstp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.data.func),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sstp_dp #(
    .EVENT_SLOTS  (EVENT_SLOTS),
    .PLAYED_SLOTS (PLAYED_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

FILE: src/sstp_ctrl.sv
`default_nettype none
module sstp_ctrl import sstp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic [2:0] in_func,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          case (in_func)
            FN_TICK:   state_next = ST_TIME;
            FN_ADD:    state_next = status.table_full ? ST_DONE : ST_ADD;
            FN_REMOVE: state_next = ST_REM;
            FN_FLUSH:  state_next = ST_FLUSH;
            FN_COUNT:  state_next = ST_CNT;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_TIME: begin
        cmd.op     = OP_TIME;
        state_next = ST_ON;
      end
      ST_ON: begin
        if (!status.on_due) begin
          state_next = ST_OFF;
        end else if (!status.note_ok || status.out_free) begin
          cmd.op = OP_ON;
        end
      end
      ST_OFF: begin
        if (status.slot_end) begin
          state_next = ST_DONE;
        end else if (!status.off_emit || status.out_free) begin
          cmd.op = OP_OFF;
        end
      end
      ST_FLUSH: begin
        if (status.slot_end) begin
          state_next = ST_DONE;
        end else if (!status.slot_valid || status.out_free) begin
          cmd.op = OP_FLUSH;
        end
      end
      ST_ADD: begin
        cmd.op = OP_ADD;
        if (status.add_fin) state_next = ST_DONE;
      end
      ST_REM: begin
        if (status.scan_end) begin
          cmd.op     = OP_REM_FIN;
          state_next = ST_DONE;
        end else begin
          cmd.op = OP_REM;
        end
      end
      ST_CNT: begin
        if (status.scan_end) begin
          state_next = ST_DONE;
        end else begin
          cmd.op = OP_CNT;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.op     = OP_DONE;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/sstp_dp.sv
`default_nettype none
module sstp_dp import sstp_pkg::*; #(
  parameter int EVENT_SLOTS  = EV_SLOTS_DEF,
  parameter int PLAYED_SLOTS = PL_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire in_t                   in_data,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  sstp_out_if.source                 out_ch
);

  localparam int EV_IW = $clog2(EVENT_SLOTS);
  localparam int CW    = $clog2(EVENT_SLOTS + 1);
  localparam int PL_IW = $clog2(PLAYED_SLOTS);
  localparam int PW    = $clog2(PLAYED_SLOTS + 1);
  localparam logic [EV_IW-1:0] NE_MAX  = EV_IW'(EVENT_SLOTS - 1);
  localparam logic [CW-1:0]    EV_FULL = CW'(EVENT_SLOTS);
  localparam logic [PW-1:0]    PL_END  = PW'(PLAYED_SLOTS);

  // configuration
  logic [TICK_W-1:0] last_tick;
  logic [2:0]        speed;
  logic [CH_W-1:0]   out_chan;
  logic              note_is_ch;
  logic [7:0]        transpose;

  // track state
  ev_t               ev_mem [EVENT_SLOTS];
  held_t             pl_mem [PLAYED_SLOTS];
  logic [PLAYED_SLOTS-1:0] pl_valid;
  logic [CW-1:0]     used;
  logic [TICK_W-1:0] cur_time;
  logic [EV_IW-1:0]  ne;
  logic [1:0]        pc;
  logic              muted, cue_pend, cue_val;
  logic [1:0]        step_r;
  in_t               req;
  logic [CW-1:0]     idx, wr;
  logic [PW-1:0]     slot;
  logic [CNT_W-1:0]  cnt;
  logic              out_valid;
  out_t              out_q;

  // reads
  logic [CW-1:0]     idx_m1;
  logic [EV_IW-1:0]  rd_addr;
  ev_t               ev_rd;
  held_t             pl_rd;
  logic              pl_v;
  logic              match;
  logic signed [8:0] nv;
  logic              note_ok;
  logic [CH_W-1:0]   ch_on;
  logic              free_any;
  logic [PL_IW-1:0]  free_idx;
  logic [1:0]        mstat;
  logic              add_fin;

  assign idx_m1  = idx - CW'(1);
  assign rd_addr = (req.func == FN_ADD) ? idx_m1[EV_IW-1:0] : idx[EV_IW-1:0];
  assign ev_rd   = ev_mem[rd_addr];
  assign pl_rd   = pl_mem[slot[PL_IW-1:0]];
  assign pl_v    = (slot < PL_END) && pl_valid[slot[PL_IW-1:0]];
  assign match   = (ev_rd.tick >= req.tick_value) && (ev_rd.tick <= req.tick_end) &&
                   (ev_rd.note == req.note_number);
  assign nv      = $signed({2'b00, ev_rd.note}) + $signed({transpose[7], transpose});
  assign note_ok = (nv[8:7] == 2'b00);
  assign add_fin = (idx == '0) || (ev_rd.tick <= req.tick_value);

  always_comb begin
    if (!note_is_ch) begin
      ch_on = out_chan;
    end else if (nv[6:0] == 7'd0) begin
      ch_on = CH_W'(1);
    end else if (nv[6:0] > 7'd16) begin
      ch_on = CH_W'(16);
    end else begin
      ch_on = nv[CH_W-1:0];
    end
  end

  // first empty played slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = PLAYED_SLOTS - 1; i >= 0; i--) begin
      if (!pl_valid[i]) begin
        free_any = 1'b1;
        free_idx = PL_IW'(i);
      end
    end
  end

  always_comb begin
    if (muted && !cue_pend) mstat = MS_ON;
    else if (!muted && cue_pend && cue_val) mstat = MS_ON_CUED;
    else if (muted && cue_pend && !cue_val) mstat = MS_OFF_CUED;
    else mstat = MS_OFF;
  end

  // time step and wrap
  logic [1:0]        pc_n;
  logic [1:0]        st;
  logic [2:0]        div;
  logic              use_div;
  logic [2:0]        pc1;
  logic [TICK_W:0]   sum;
  logic              wrap;

  always_comb begin
    st      = 2'd0;
    div     = 3'd4;
    use_div = 1'b0;
    pc_n    = pc;
    pc1     = {1'b0, pc} + 3'd1;
    case (speed)
      SPD_X1:      st = 2'd1;
      SPD_X2:      st = 2'd2;
      SPD_QUARTER: begin div = 3'd4; use_div = 1'b1; end
      SPD_THIRD:   begin div = 3'd3; use_div = 1'b1; end
      SPD_HALF:    begin div = 3'd2; use_div = 1'b1; end
      default:     st = 2'd0;
    endcase
    if (use_div) begin
      if (pc1 >= div) begin
        pc_n = 2'd0;
        st   = 2'd1;
      end else begin
        pc_n = pc1[1:0];
      end
    end
  end

  assign sum  = {1'b0, cur_time} + (TICK_W + 1)'(st);
  assign wrap = sum > {1'b0, last_tick};

  // write and emit selection
  logic              ev_we;
  logic [EV_IW-1:0]  ev_wa;
  ev_t               ev_wd;
  logic              pl_we;
  logic [PL_IW-1:0]  pl_wa;
  held_t             pl_wd;
  logic              emit;
  out_t              emit_d;

  always_comb begin
    ev_we  = 1'b0;
    ev_wa  = idx[EV_IW-1:0];
    ev_wd  = ev_rd;
    pl_we  = 1'b0;
    pl_wa  = slot[PL_IW-1:0];
    pl_wd  = pl_rd;
    emit   = 1'b0;
    emit_d = '0;
    emit_d.track_time  = cur_time;
    emit_d.mute_status = mstat;
    case (cmd.op)
      OP_ON: begin
        if (note_ok) begin
          emit                = 1'b1;
          emit_d.kind         = KIND_ON;
          emit_d.channel      = ch_on;
          emit_d.note_out     = nv[6:0];
          emit_d.velocity_out = ev_rd.vel;
          if (free_any) begin
            pl_we = 1'b1;
            pl_wa = free_idx;
            pl_wd = '{note: nv[6:0], vel: ev_rd.vel, dur: ev_rd.dur};
          end
        end
      end
      OP_OFF: begin
        if (pl_v) begin
          if (pl_rd.dur == '0) begin
            emit            = 1'b1;
            emit_d.kind     = KIND_OFF;
            emit_d.channel  = out_chan;
            emit_d.note_out = pl_rd.note;
          end else begin
            pl_we     = 1'b1;
            pl_wd.dur = (pl_rd.dur > DUR_W'(step_r)) ? pl_rd.dur - DUR_W'(step_r) : '0;
          end
        end
      end
      OP_FLUSH: begin
        if (pl_v) begin
          emit                = 1'b1;
          emit_d.kind         = KIND_OFF;
          emit_d.channel      = out_chan;
          emit_d.note_out     = pl_rd.note;
          emit_d.velocity_out = pl_rd.vel;
        end
      end
      OP_ADD: begin
        ev_we = 1'b1;
        if (add_fin) begin
          ev_wd = '{tick: req.tick_value, note: req.note_number,
                    vel: req.note_velocity, dur: req.note_duration};
        end
      end
      OP_REM: begin
        if (!match) begin
          ev_we = 1'b1;
          ev_wa = wr[EV_IW-1:0];
        end
      end
      OP_DONE: begin
        emit               = 1'b1;
        emit_d.kind        = KIND_DONE;
        emit_d.match_count = cnt;
        emit_d.last        = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (ev_we) ev_mem[ev_wa] <= ev_wd;
    if (pl_we) pl_mem[pl_wa] <= pl_wd;
    if (emit) out_q <= emit_d;
    if (cmd.op == OP_LOAD) req <= in_data;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick  <= TICK_W'(47);
      speed      <= SPD_X1;
      out_chan   <= CH_W'(1);
      note_is_ch <= 1'b0;
      transpose  <= '0;
      pl_valid   <= '0;
      used       <= '0;
      cur_time   <= '0;
      ne         <= '0;
      pc         <= '0;
      muted      <= 1'b0;
      cue_pend   <= 1'b0;
      cue_val    <= 1'b0;
      step_r     <= '0;
      idx        <= '0;
      wr         <= '0;
      slot       <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_ch.ready) out_valid <= 1'b0;
      if (emit) out_valid <= 1'b1;
      if (cfg_we) begin
        case (cfg_index)
          REG_LAST_TICK: last_tick  <= cfg_data[TICK_W-1:0];
          REG_SPEED:     speed      <= cfg_data[2:0];
          REG_CHANNEL:   out_chan   <= cfg_data[CH_W-1:0];
          REG_NOTE_CH:   note_is_ch <= cfg_data[0];
          REG_TRANSPOSE: transpose  <= cfg_data[7:0];
          default:       ;
        endcase
      end
      if (pl_we && cmd.op == OP_ON) pl_valid[pl_wa] <= 1'b1;
      case (cmd.op)
        OP_LOAD: begin
          idx  <= (in_data.func == FN_ADD) ? used : '0;
          wr   <= '0;
          cnt  <= '0;
          slot <= '0;
          if (in_data.func == FN_CUE) begin
            cue_pend <= 1'b1;
            cue_val  <= in_data.mute_wanted;
          end
        end
        OP_TIME: begin
          pc <= pc_n;
          if (wrap) begin
            cur_time <= '0;
            ne       <= '0;
            step_r   <= '0;
            idx      <= '0;
            if (cue_pend) begin
              muted    <= cue_val;
              cue_pend <= 1'b0;
            end
          end else begin
            cur_time <= sum[TICK_W-1:0];
            step_r   <= st;
            idx      <= CW'(ne);
          end
        end
        OP_ON: begin
          idx <= idx + CW'(1);
          if (ne != NE_MAX) ne <= ne + EV_IW'(1);
        end
        OP_OFF: begin
          if (pl_v && pl_rd.dur == '0) pl_valid[slot[PL_IW-1:0]] <= 1'b0;
          slot <= slot + PW'(1);
        end
        OP_FLUSH: begin
          if (pl_v) pl_valid[slot[PL_IW-1:0]] <= 1'b0;
          slot <= slot + PW'(1);
        end
        OP_ADD: begin
          if (add_fin) begin
            used <= used + CW'(1);
            if (req.tick_value < cur_time && ne != NE_MAX) ne <= ne + EV_IW'(1);
          end else begin
            idx <= idx_m1;
          end
        end
        OP_REM: begin
          idx <= idx + CW'(1);
          if (match) begin
            if (ev_rd.tick < cur_time && ne != '0) ne <= ne - EV_IW'(1);
          end else begin
            wr <= wr + CW'(1);
          end
        end
        OP_REM_FIN: used <= wr;
        OP_CNT: begin
          idx <= idx + CW'(1);
          if (match) cnt <= cnt + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_q;

  assign status.out_free   = !out_valid || out_ch.ready;
  assign status.on_due     = !muted && (idx < used) && (ev_rd.tick <= cur_time);
  assign status.note_ok    = note_ok;
  assign status.off_emit   = pl_v && (pl_rd.dur == '0);
  assign status.slot_valid = pl_v;
  assign status.slot_end   = (slot == PL_END);
  assign status.add_fin    = add_fin;
  assign status.scan_end   = (idx == used);
  assign status.table_full = (used == EV_FULL);

endmodule
`default_nettype wire

FILE: src/sstp_chk.sv
`default_nettype none
module sstp_chk import sstp_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // one command in service at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while busy");

  a_done_fmt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_DONE |->
      out_data.last && out_data.channel == '0 && out_data.note_out == '0 &&
      out_data.velocity_out == '0)
    else $error("malformed done word");

  a_note_fmt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_DONE |->
      !out_data.last && out_data.match_count == '0)
    else $error("malformed note word");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind step_sequencer_track_player sstp_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire
